// ===== sv/fcs_pkg.sv =====
// Shared types and constants for the Fourier contour synthesis block.
// Used by every module of the block; depends on nothing.

package fcs_pkg;

    localparam int IDX_W       = 4;
    localparam int SAMPLE_W    = 9;
    localparam int COEF_W      = 32;
    localparam int BASIS_W     = 16;
    localparam int PROD_W      = COEF_W + BASIS_W;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 80;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef struct packed {
        logic signed [COEF_W-1:0] y_sin;
        logic signed [COEF_W-1:0] y_cos;
        logic signed [COEF_W-1:0] x_sin;
        logic signed [COEF_W-1:0] x_cos;
    } fcs_coef_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } fcs_mac_ctrl_t;

endpackage

// ===== sv/fourier_contour_synthesis.sv =====
// Fourier contour synthesis top level: sequencer, output register and wiring.
// Instantiates fcs_basis_rom, fcs_coef_store and fcs_mac; uses fcs_pkg.
//
// Input stream (s_axis_*): tuser selects the function. A load (tuser 0) writes
// the four Q16.16 coefficients of one harmonic slot in the cycle of the
// transfer and gives no result; a slot at or above HARMONICS is ignored. An
// evaluate (tuser 1) synthesizes one contour point for sample index k.
// Output stream (m_axis_*): one transfer per evaluate carrying k, the x and y
// coordinates (Q16.16, rounded, saturated) and the saturation flag in tuser.
// Timing: a load leaves tready high. An evaluate reduces k modulo SAMPLES,
// then runs one harmonic per cycle through the shared MAC, drains the ROM/store
// read and product stages and rounds. tready is low meanwhile and returns
// together with the point being registered in the output register.
// The finished point sits in the output register; a stalled receiver holds
// the block in its rounding step only if a second point is ready before the
// first is taken. Reset clears all coefficient slots to zero and empties the
// output register.

module fourier_contour_synthesis #(
    parameter int SAMPLES   = 512,
    parameter int HARMONICS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // harmonic_index, coef_x_cos, coef_x_sin, coef_y_cos, coef_y_sin, sample_index
    input  logic [fcs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // func
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // point_index, x_value, y_value
    output logic [fcs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // saturated
    output logic                                m_axis_tuser
);

    localparam int AW   = $clog2(SAMPLES);
    localparam int KW   = (AW > fcs_pkg::SAMPLE_W) ? AW : fcs_pkg::SAMPLE_W;
    localparam int SW   = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
    localparam int IW   = (SW > fcs_pkg::IDX_W) ? SW : fcs_pkg::IDX_W;
    localparam int ACCW = fcs_pkg::PROD_W + $clog2(2 * HARMONICS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [KW-1:0]                 k_work_reg, k_work_next;
    logic [AW-1:0]                 angle_reg, angle_next;
    logic [SW-1:0]                 h_reg, h_next;
    logic                          drain_reg, drain_next;
    logic                          rd_valid_reg;
    logic [fcs_pkg::SAMPLE_W-1:0]  point_reg, point_next;
    logic [fcs_pkg::SAMPLE_W-1:0]  out_point_reg, out_point_next;
    logic                          m_valid_reg, m_valid_next;
    logic [fcs_pkg::COEF_W-1:0]    x_reg, x_next;
    logic [fcs_pkg::COEF_W-1:0]    y_reg, y_next;
    logic                          sat_reg, sat_next;

    logic                          accept;
    logic                          issue;
    logic [IW-1:0]                 slot_wide;
    logic                          wr_en;
    fcs_pkg::fcs_coef_t            wr_data;
    fcs_pkg::fcs_coef_t            rd_data;
    logic signed [fcs_pkg::BASIS_W-1:0] cos_val;
    logic signed [fcs_pkg::BASIS_W-1:0] sin_val;
    fcs_pkg::fcs_mac_ctrl_t        mac_ctrl;
    logic signed [ACCW-1:0]        acc_x;
    logic signed [ACCW-1:0]        acc_y;
    logic [AW:0]                   angle_sum;
    logic [32:0]                   rx;
    logic [32:0]                   ry;

    function automatic logic [32:0] round_sat(input logic signed [ACCW-1:0] a);
        logic signed [ACCW:0] t;
        logic [32:0]          res;
        t = $signed({a[ACCW-1], a}) + $signed((ACCW + 1)'(16384));
        if ((&t[ACCW:46]) || !(|t[ACCW:46]))
        begin
            res = {1'b0, t[46:15]};
        end
        else if (t[ACCW])
        begin
            res = {1'b1, 32'h8000_0000};
        end
        else
        begin
            res = {1'b1, 32'h7FFF_FFFF};
        end
        return res;
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign issue         = (state_reg == ST_RUN);

    assign slot_wide     = IW'(s_axis_tdata[3:0]);
    assign wr_en         = accept && (s_axis_tuser == fcs_pkg::FUNC_LOAD)
                           && ({1'b0, slot_wide} < (IW + 1)'(HARMONICS));
    assign wr_data.x_cos = s_axis_tdata[35:4];
    assign wr_data.x_sin = s_axis_tdata[67:36];
    assign wr_data.y_cos = s_axis_tdata[99:68];
    assign wr_data.y_sin = s_axis_tdata[131:100];

    assign mac_ctrl.clear  = accept && (s_axis_tuser == fcs_pkg::FUNC_EVAL);
    assign mac_ctrl.mul_en = rd_valid_reg;

    assign angle_sum = {1'b0, angle_reg} + {1'b0, k_work_reg[AW-1:0]};
    assign rx        = round_sat(acc_x);
    assign ry        = round_sat(acc_y);

    always_comb
    begin
        state_next     = state_reg;
        k_work_next    = k_work_reg;
        angle_next     = angle_reg;
        h_next         = h_reg;
        drain_next     = drain_reg;
        point_next     = point_reg;
        out_point_next = out_point_reg;
        m_valid_next   = m_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        sat_next       = sat_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_axis_tuser == fcs_pkg::FUNC_EVAL))
                begin
                    k_work_next = KW'(s_axis_tdata[140:132]);
                    point_next  = s_axis_tdata[140:132];
                    state_next  = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if ({1'b0, k_work_reg} >= (KW + 1)'(SAMPLES))
                begin
                    k_work_next = k_work_reg - KW'(SAMPLES);
                end
                else
                begin
                    angle_next = k_work_reg[AW-1:0];
                    h_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (angle_sum >= (AW + 1)'(SAMPLES))
                begin
                    angle_next = AW'(angle_sum - (AW + 1)'(SAMPLES));
                end
                else
                begin
                    angle_next = AW'(angle_sum);
                end
                h_next = h_reg + 1'b1;
                if (h_reg == SW'(HARMONICS - 1))
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next   = 1'b1;
                    out_point_next = point_reg;
                    x_next         = rx[31:0];
                    y_next         = ry[31:0];
                    sat_next       = rx[32] || ry[32];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            drain_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            drain_reg    <= drain_next;
            rd_valid_reg <= issue;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_work_reg    <= k_work_next;
        angle_reg     <= angle_next;
        h_reg         <= h_next;
        point_reg     <= point_next;
        out_point_reg <= out_point_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        sat_reg       <= sat_next;
    end

    fcs_basis_rom #(
        .SAMPLES (SAMPLES),
        .AW      (AW)
    ) u_rom (
        .clk     (clk),
        .addr    (angle_reg),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    fcs_coef_store #(
        .HARMONICS (HARMONICS),
        .SW        (SW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (slot_wide[SW-1:0]),
        .wr_data (wr_data),
        .rd_addr (h_reg),
        .rd_data (rd_data)
    );

    fcs_mac #(
        .ACCW (ACCW)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .coef    (rd_data),
        .cos_val (cos_val),
        .sin_val (sin_val),
        .acc_x   (acc_x),
        .acc_y   (acc_y)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, y_reg, x_reg, out_point_reg};
    assign m_axis_tuser  = sat_reg;

endmodule

// ===== sv/fcs_basis_rom.sv =====
// Cosine and sine basis ROMs, Q1.15, indexed by angle index, registered read.
// Contents are built at elaboration from a Taylor series; uses fcs_pkg.

module fcs_basis_rom #(
    parameter int SAMPLES = 512,
    parameter int AW      = 9
) (
    input  logic                                clk,
    input  logic [AW-1:0]                       addr,
    output logic signed [fcs_pkg::BASIS_W-1:0]  cos_val,
    output logic signed [fcs_pkg::BASIS_W-1:0]  sin_val
);

    localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182};
    localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};

    function automatic logic [63:0] clamp_q30(input logic signed [64:0] acc);
        logic [63:0] res;
        if (acc < 0)
        begin
            res = '0;
        end
        else if (acc > $signed({1'b0, fcs_pkg::ONE_Q30}))
        begin
            res = fcs_pkg::ONE_Q30;
        end
        else
        begin
            res = acc[63:0];
        end
        return res;
    endfunction

    function automatic logic [63:0] cos_series(input logic [63:0] x2);
        logic [63:0]        term;
        logic signed [64:0] acc;
        term = fcs_pkg::ONE_Q30;
        acc  = $signed({1'b0, term});
        for (int i = 0; i < 7; i++)
        begin
            term = ((term * x2) >> 30) / COS_DIV[i];
            if ((i % 2) == 0)
            begin
                acc = acc - $signed({1'b0, term});
            end
            else
            begin
                acc = acc + $signed({1'b0, term});
            end
        end
        return clamp_q30(acc);
    endfunction

    function automatic logic [63:0] sin_series(input logic [63:0] x2, input logic [63:0] x);
        logic [63:0]        term;
        logic signed [64:0] acc;
        term = x;
        acc  = $signed({1'b0, term});
        for (int i = 0; i < 7; i++)
        begin
            term = ((term * x2) >> 30) / SIN_DIV[i];
            if ((i % 2) == 0)
            begin
                acc = acc - $signed({1'b0, term});
            end
            else
            begin
                acc = acc + $signed({1'b0, term});
            end
        end
        return clamp_q30(acc);
    endfunction

    function automatic logic signed [15:0] to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd16384) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return $signed(r[15:0]);
    endfunction

    function automatic logic signed [15:0] basis_q15(input logic [63:0] p);
        logic [63:0]        q;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic signed [15:0] res;
        q  = (p / SAMPLES) % 4;
        r  = p % SAMPLES;
        x  = (r * fcs_pkg::HALF_PI_Q30) / SAMPLES;
        x2 = (x * x) >> 30;
        c  = to_q15(cos_series(x2));
        s  = to_q15(sin_series(x2, x));
        case (q[1:0])
            2'd0:    res = c;
            2'd1:    res = -s;
            2'd2:    res = -c;
            default: res = s;
        endcase
        return res;
    endfunction

    logic signed [fcs_pkg::BASIS_W-1:0] cos_rom [SAMPLES];
    logic signed [fcs_pkg::BASIS_W-1:0] sin_rom [SAMPLES];

    for (genvar i = 0; i < SAMPLES; i++)
    begin : g_rom
        assign cos_rom[i] = basis_q15(64'(4 * i));
        assign sin_rom[i] = basis_q15(64'((4 * i + 3 * SAMPLES) % (4 * SAMPLES)));
    end

    always_ff @(posedge clk)
    begin
        cos_val <= cos_rom[addr];
        sin_val <= sin_rom[addr];
    end

endmodule

// ===== sv/fcs_coef_store.sv =====
// Coefficient store: one four-coefficient entry per harmonic slot.
// Per-slot valid bits make unwritten slots read as zero; uses fcs_pkg.

module fcs_coef_store #(
    parameter int HARMONICS = 16,
    parameter int SW        = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [SW-1:0]       wr_addr,
    input  fcs_pkg::fcs_coef_t  wr_data,
    input  logic [SW-1:0]       rd_addr,
    output fcs_pkg::fcs_coef_t  rd_data
);

    fcs_pkg::fcs_coef_t mem [HARMONICS];
    fcs_pkg::fcs_coef_t data_reg;
    logic [HARMONICS-1:0] valid_reg;
    logic                 hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            hit_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

// ===== sv/fcs_mac.sv =====
// Shared multiply-accumulate unit: four coefficient-by-basis products per
// harmonic, registered, then summed into the x and y accumulators. Uses fcs_pkg.

module fcs_mac #(
    parameter int ACCW = 53
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fcs_pkg::fcs_mac_ctrl_t              ctrl,
    input  fcs_pkg::fcs_coef_t                  coef,
    input  logic signed [fcs_pkg::BASIS_W-1:0]  cos_val,
    input  logic signed [fcs_pkg::BASIS_W-1:0]  sin_val,
    output logic signed [ACCW-1:0]              acc_x,
    output logic signed [ACCW-1:0]              acc_y
);

    logic signed [fcs_pkg::PROD_W-1:0] p_xc_reg;
    logic signed [fcs_pkg::PROD_W-1:0] p_xs_reg;
    logic signed [fcs_pkg::PROD_W-1:0] p_yc_reg;
    logic signed [fcs_pkg::PROD_W-1:0] p_ys_reg;
    logic                              p_valid_reg;
    logic signed [ACCW-1:0]            acc_x_reg;
    logic signed [ACCW-1:0]            acc_y_reg;

    always_ff @(posedge clk)
    begin
        p_xc_reg <= coef.x_cos * cos_val;
        p_xs_reg <= coef.x_sin * sin_val;
        p_yc_reg <= coef.y_cos * cos_val;
        p_ys_reg <= coef.y_sin * sin_val;
        if (ctrl.clear)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (p_valid_reg)
        begin
            acc_x_reg <= acc_x_reg + ACCW'(p_xc_reg) + ACCW'(p_xs_reg);
            acc_y_reg <= acc_y_reg + ACCW'(p_yc_reg) + ACCW'(p_ys_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= ctrl.mul_en;
        end
    end

    assign acc_x = acc_x_reg;
    assign acc_y = acc_y_reg;

endmodule

// ===== sv/fcs_checker.sv =====
// Port-level checks for fourier_contour_synthesis, bound to the top level.
// Uses fcs_pkg for port widths and function codes.

module fcs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [fcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    // a load transfer leaves the input ready in the next cycle
    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == fcs_pkg::FUNC_LOAD)
        |=> s_axis_tready)
        else $error("input not ready after load transfer");

    // evaluate occupies the sequencer
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == fcs_pkg::FUNC_EVAL)
        |=> !s_axis_tready)
        else $error("input ready right after evaluate transfer");

    // a new point appears only as the sequencer finishes
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while sequencer idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output transfer changed");

endmodule

bind fourier_contour_synthesis fcs_checker u_fcs_checker (.*);

// ===== tb/sv/tb.sv =====
// Stream testbench for fourier_contour_synthesis: a directed table, then random
// contours (coefficient loads followed by evaluates), checked against the
// table or a behavioral model of the synthesis. Depends on fcs_pkg and the RTL.

module tb;

    localparam int SAMPLES        = 512;
    localparam int HARMONICS      = 16;
    localparam int RANDOM_ITEMS   = 830;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 40;

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONEV = 32'sh0001_0000;

    localparam logic FL = fcs_pkg::FUNC_LOAD;
    localparam logic FE = fcs_pkg::FUNC_EVAL;

    typedef enum int {SCALE_UNIT, SCALE_WIDE, SCALE_FULL, SCALE_EDGE} coef_scale_t;

    typedef struct packed {
        logic [8:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } contour_point_t;

    typedef struct packed {
        logic               func;
        logic [3:0]         slot;
        logic signed [31:0] xc;
        logic signed [31:0] xs;
        logic signed [31:0] yc;
        logic signed [31:0] ys;
        logic [8:0]         k;
        logic               typed;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic               esat;
    } directed_row_t;

    localparam directed_row_t DIRECTED [22] = '{
        '{FE, 4'd0,  0,    0,    0,    0,    9'd0,   1'b1, 0,    0,    1'b0},
        '{FE, 4'd9,  MAXV, MINV, MAXV, MINV, 9'd511, 1'b1, 0,    0,    1'b0},
        '{FL, 4'd0,  MAXV, MINV, MINV, MAXV, 9'd511, 1'b0, 0,    0,    1'b0},
        '{FL, 4'd1,  MAXV, MINV, MINV, MAXV, 9'd0,   1'b0, 0,    0,    1'b0},
        '{FE, 4'd15, 0,    0,    0,    0,    9'd0,   1'b1, MAXV, MINV, 1'b1},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd128, 1'b0, 0,    0,    1'b0},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd256, 1'b0, 0,    0,    1'b0},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd384, 1'b0, 0,    0,    1'b0},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd1,   1'b0, 0,    0,    1'b0},
        '{FL, 4'd15, MINV, MINV, MINV, MINV, 9'd0,   1'b0, 0,    0,    1'b0},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd511, 1'b0, 0,    0,    1'b0},
        '{FL, 4'd0,  0,    0,    0,    0,    9'd0,   1'b0, 0,    0,    1'b0},
        '{FL, 4'd1,  0,    0,    0,    0,    9'd0,   1'b0, 0,    0,    1'b0},
        '{FL, 4'd15, 0,    0,    0,    0,    9'd0,   1'b0, 0,    0,    1'b0},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd0,   1'b1, 0,    0,    1'b0},
        '{FL, 4'd7,  1,    -1,   ONEV, -ONEV, 9'd3,  1'b0, 0,    0,    1'b0},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd37,  1'b0, 0,    0,    1'b0},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd255, 1'b0, 0,    0,    1'b0},
        '{FL, 4'd7,  0,    0,    0,    0,    9'd0,   1'b0, 0,    0,    1'b0},
        '{FL, 4'd3,  ONEV, ONEV, ONEV, ONEV, 9'd0,   1'b0, 0,    0,    1'b0},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd0,   1'b0, 0,    0,    1'b0},
        '{FE, 4'd0,  0,    0,    0,    0,    9'd170, 1'b0, 0,    0,    1'b0}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [fcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [fcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;

    fcs_pkg::fcs_coef_t harmonic_coefs [HARMONICS];
    int                 cos_q15 [SAMPLES];
    int                 sin_q15 [SAMPLES];
    contour_point_t     pending_points [$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    bit                 hold_request = 1'b0;
    bit                 hold_done = 1'b0;

    fourier_contour_synthesis #(
        .SAMPLES   (SAMPLES),
        .HARMONICS (HARMONICS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Taylor series in Q2.30, alternating signs, clamped to [0, 1.0]
    function automatic longint unsigned taylor_q30(input longint unsigned x2,
                                                   input longint unsigned first,
                                                   input int unsigned start);
        longint unsigned term;
        longint          acc;
        int unsigned     n;
        term = first;
        acc  = longint'(first);
        n    = start;
        for (int i = 1; i < 8; i++)
        begin
            term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
            n += 2;
            if (i % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(fcs_pkg::ONE_Q30))
            acc = longint'(fcs_pkg::ONE_Q30);
        return longint'(acc);
    endfunction

    function automatic int to_q15(input longint unsigned v);
        longint unsigned r;
        r = (v + 64'd16384) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return int'(r);
    endfunction

    // phase p in quarter steps of the sample circle
    function automatic int basis_q15(input int unsigned p);
        int unsigned     quad;
        longint unsigned rem;
        longint unsigned xq;
        longint unsigned x2;
        int              c;
        int              s;
        quad = (p / SAMPLES) % 4;
        rem  = p % SAMPLES;
        xq   = (rem * fcs_pkg::HALF_PI_Q30) / SAMPLES;
        x2   = (xq * xq) >> 30;
        c    = to_q15(taylor_q30(x2, fcs_pkg::ONE_Q30, 0));
        s    = to_q15(taylor_q30(x2, xq, 1));
        case (quad)
            0:       return c;
            1:       return -s;
            2:       return -c;
            default: return s;
        endcase
    endfunction

    // {clipped, value}
    function automatic logic [32:0] round_clip(input longint sum);
        longint r;
        r = (sum + 64'sd16384) >>> 15;
        if (r > 64'sh7FFF_FFFF)
            return {1'b1, MAXV};
        if (r < -64'sh8000_0000)
            return {1'b1, MINV};
        return {1'b0, r[31:0]};
    endfunction

    function automatic contour_point_t synth_point(input logic [8:0] k);
        longint         sum_x;
        longint         sum_y;
        int unsigned    angle;
        logic [32:0]    rx;
        logic [32:0]    ry;
        contour_point_t pt;
        sum_x = 0;
        sum_y = 0;
        for (int unsigned h = 1; h <= HARMONICS; h++)
        begin
            angle = (h * k) % SAMPLES;
            sum_x += longint'(harmonic_coefs[h-1].x_cos) * cos_q15[angle]
                   + longint'(harmonic_coefs[h-1].x_sin) * sin_q15[angle];
            sum_y += longint'(harmonic_coefs[h-1].y_cos) * cos_q15[angle]
                   + longint'(harmonic_coefs[h-1].y_sin) * sin_q15[angle];
        end
        rx = round_clip(sum_x);
        ry = round_clip(sum_y);
        pt.idx = k;
        pt.x   = rx[31:0];
        pt.y   = ry[31:0];
        pt.sat = rx[32] | ry[32];
        return pt;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap(input bit calm);
        return (calm || $urandom_range(0, 99) < 65) ? 0 : gap_len();
    endfunction

    function automatic logic signed [31:0] pick_coef(input coef_scale_t scale);
        case (scale)
            SCALE_UNIT: return int'($urandom_range(0, 262143)) - 131072;
            SCALE_WIDE: return $signed($urandom) >>> 6;
            SCALE_FULL: return $urandom;
            default:
                case ($urandom_range(0, 5))
                    0:       return MAXV;
                    1:       return MINV;
                    2:       return 0;
                    3:       return -1;
                    4:       return 1;
                    default: return ONEV;
                endcase
        endcase
    endfunction

    function automatic fcs_pkg::fcs_coef_t random_coefs(input coef_scale_t scale);
        fcs_pkg::fcs_coef_t cf;
        cf.x_cos = pick_coef(scale);
        cf.x_sin = pick_coef(scale);
        cf.y_cos = pick_coef(scale);
        cf.y_sin = pick_coef(scale);
        return cf;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= 40)
            $display("%0t: point %s mismatch, expected %0d got %0d", $realtime, what, want, got);
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic push_item(input logic func, input logic [3:0] slot,
                             input fcs_pkg::fcs_coef_t cf,
                             input logic [8:0] k, input int gap, input bit typed,
                             input contour_point_t typed_pt);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {3'b000, k, cf.y_sin, cf.y_cos, cf.x_sin, cf.x_cos, slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (func == fcs_pkg::FUNC_LOAD)
            harmonic_coefs[slot] = cf;
        else
            pending_points.push_back(typed ? typed_pt : synth_point(k));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : check_points
        contour_point_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_points.size() == 0)
                report_mismatch("unexpected transfer, index", -1, m_axis_tdata[8:0]);
            else
            begin
                want = pending_points.pop_front();
                if (m_axis_tdata[8:0] != want.idx)
                    report_mismatch("index", want.idx, m_axis_tdata[8:0]);
                if (m_axis_tdata[40:9] != want.x)
                    report_mismatch("x", want.x, $signed(m_axis_tdata[40:9]));
                if (m_axis_tdata[72:41] != want.y)
                    report_mismatch("y", want.y, $signed(m_axis_tdata[72:41]));
                if (m_axis_tuser != want.sat)
                    report_mismatch("saturated", want.sat, m_axis_tuser);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls, calm stretches, and one long hold-off
    initial
    begin : receiver
        int stall_left;
        int calm_left;
        bit calm;
        stall_left = 0;
        calm_left  = 200;
        calm       = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm_left == 0)
            begin
                calm      = !calm;
                calm_left = $urandom_range(50, 300);
            end
            else
                calm_left--;
            if (hold_request && !hold_done)
            begin
                stall_left = HOLD_CYCLES;
                hold_done  = 1'b1;
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 99) < 15)
                stall_left = gap_len();
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        directed_row_t      row;
        fcs_pkg::fcs_coef_t cf;
        contour_point_t     typed_pt;
        coef_scale_t        scale;
        int                 sent;
        int                 n_loads;
        int                 n_evals;
        bit                 in_order;
        logic [8:0]         k;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = fcs_pkg::FUNC_LOAD;
        foreach (harmonic_coefs[i])
            harmonic_coefs[i] = '0;
        for (int i = 0; i < SAMPLES; i++)
        begin
            cos_q15[i] = basis_q15(4 * i);
            sin_q15[i] = basis_q15((4 * i + 3 * SAMPLES) % (4 * SAMPLES));
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            row = DIRECTED[i];
            cf.x_cos = row.xc;
            cf.x_sin = row.xs;
            cf.y_cos = row.yc;
            cf.y_sin = row.ys;
            typed_pt.idx = row.k;
            typed_pt.x   = row.ex;
            typed_pt.y   = row.ey;
            typed_pt.sat = row.esat;
            push_item(row.func, row.slot, cf, row.k, sender_gap(1'b0), row.typed, typed_pt);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= 400)
                hold_request = 1'b1;
            if ($urandom_range(0, 9) == 0)
            begin
                push_item($urandom_range(0, 1), $urandom_range(0, 15),
                          random_coefs(SCALE_FULL), $urandom_range(0, 511),
                          sender_gap(1'b0), 1'b0, typed_pt);
                sent++;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6:     scale = SCALE_UNIT;
                    7, 8, 9, 10, 11, 12, 13: scale = SCALE_WIDE;
                    14, 15, 16:              scale = SCALE_FULL;
                    default:                 scale = SCALE_EDGE;
                endcase
                n_loads  = $urandom_range(1, HARMONICS);
                n_evals  = $urandom_range(1, 6);
                in_order = $urandom_range(0, 1);
                for (int j = 0; j < n_loads; j++)
                begin
                    push_item(fcs_pkg::FUNC_LOAD, in_order ? j : $urandom_range(0, 15),
                              random_coefs(scale), $urandom_range(0, 511),
                              sender_gap(((sent / 50) % 5) == 4), 1'b0, typed_pt);
                    sent++;
                end
                for (int j = 0; j < n_evals; j++)
                begin
                    case ($urandom_range(0, 11))
                        0:       k = 9'd0;
                        1:       k = 9'd511;
                        2:       k = 9'd64 * $urandom_range(0, 7);
                        default: k = $urandom_range(0, 511);
                    endcase
                    push_item(fcs_pkg::FUNC_EVAL, $urandom_range(0, 15),
                              random_coefs(SCALE_FULL), k,
                              sender_gap(((sent / 50) % 5) == 4), 1'b0, typed_pt);
                    sent++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== fourier_contour_synthesis.f =====
sv/fcs_pkg.sv
sv/fcs_basis_rom.sv
sv/fcs_coef_store.sv
sv/fcs_mac.sv
sv/fourier_contour_synthesis.sv
sv/fcs_checker.sv
tb/sv/tb.sv
